/* hdl/mebm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mebm_pkg;

  localparam logic [15:0] TARGET_RESET = 16'd1024;

  typedef struct packed {
    logic [7:0]  key_byte;
    logic [62:0] time_seconds;
    logic [19:0] time_micro;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  mixed_byte;
    logic [31:0] entropy_estimate;
    logic        target_reached;
  } out_item_t;

  typedef enum logic [1:0] {F_IDLE, F_MIX, F_PUSH} front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_READ, B_UPD, B_LOG1, B_LOG2, B_OUT
  } back_state_t;

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ, L_DONE} log_state_t;

  // c*11 + c%13 + b, modulo 256; c/13 by reciprocal 79/1024 with one correction
  function automatic logic [7:0] mix_byte(input logic [7:0] c, input logic [7:0] b);
    logic [14:0] p;
    logic [4:0]  qd;
    logic [7:0]  r;
    logic [7:0]  m11;
    p   = {7'b0, c} * 15'd79;
    qd  = p[14:10];
    r   = c - ({3'b0, qd} * 8'd13);
    if (r >= 8'd13) begin
      r = r - 8'd13;
    end
    m11 = c * 8'd11;
    return m11 + r + b;
  endfunction

endpackage
`default_nettype wire

/* hdl/markov_entropy_byte_mixer.sv */
// Byte mixer with an order-1 entropy estimate.
// Input channel in_valid / in_stall / in_data: a raw byte and a timestamp.
// Result channel out_valid / out_stall / out_data: mixed byte, running
// estimate in unsigned 16.16 and the target flag, one result per request.
// cfg_we / cfg_wdata write the target in whole bits (reset 1024).
// The front stage mixes one timestamp byte a cycle, min(TIME_BYTES, 16)
// bytes a request, and hands the byte on through a two-entry queue.
// The back stage reads and updates the count tables, then runs two
// logarithms on one shared iterative unit: a leading-one search of one bit
// a cycle, then repeated squaring for 17 result bits, and a done state each.
// It takes no new byte until the previous result has gone to the output
// register; the log unit sets the throughput.
// After reset the back stage clears the pair and context tables, during
// which requests are still taken until the queue fills.
// When the receiver stalls, the result waits in the output register and
// the front keeps taking requests until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module markov_entropy_byte_mixer
  import mebm_pkg::*;
#(
  parameter int TIME_BYTES = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] target_r;
  logic        push, q_full, q_nonempty, pop;
  logic [7:0]  push_data, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  mebm_front #(.TIME_BYTES(TIME_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  mebm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  mebm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .target     (target_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

/* hdl/mebm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module mebm_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [7:0] push_data,
  output logic            full,
  input  wire logic       pop,
  output logic            nonempty,
  output logic [7:0]      head
);

  logic [7:0] mem_r [0:1];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign head     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = ~wp_r;
    end
    if (pop && nonempty) begin
      rp_nxt = ~rp_r;
    end
    if ((push && !full) && !(pop && nonempty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && (pop && nonempty)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* hdl/mebm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module mebm_front
  import mebm_pkg::*;
#(
  parameter int TIME_BYTES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          push,
  output logic [7:0]    push_data,
  input  wire logic     q_full
);

  localparam int NB = (TIME_BYTES > 16) ? 16 : TIME_BYTES;

  front_state_t st_r, st_nxt;
  logic [127:0] seq_r, seq_nxt;
  logic [7:0]   c_r, c_nxt;
  logic [4:0]   j_r, j_nxt;

  assign in_stall  = (st_r != F_IDLE);
  assign push_data = c_r;

  always_comb begin
    st_nxt  = st_r;
    seq_nxt = seq_r;
    c_nxt   = c_r;
    j_nxt   = j_r;
    push    = 1'b0;
    case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          // micro bytes follow the seconds bytes, upper bytes zero
          seq_nxt = {44'b0, in_data.time_micro, 1'b0, in_data.time_seconds};
          c_nxt   = in_data.key_byte;
          j_nxt   = '0;
          st_nxt  = F_MIX;
        end
      end
      F_MIX: begin
        c_nxt   = mix_byte(c_r, seq_r[7:0]);
        seq_nxt = {8'b0, seq_r[127:8]};
        j_nxt   = j_r + 5'd1;
        if (j_r == 5'(NB - 1)) begin
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          push   = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    c_r   <= c_nxt;
    j_r   <= j_nxt;
  end

endmodule
`default_nettype wire

/* hdl/mebm_log.sv */
`timescale 1ns / 1ps
`default_nettype none
module mebm_log
  import mebm_pkg::*;
#(
  parameter int XW = 22
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [XW-1:0] x,
  output logic               done,
  output logic [31:0]        res
);

  localparam int NW  = (XW > 32) ? XW : 32;
  localparam int NBW = $clog2(NW);
  localparam int LW  = NBW + 17;

  log_state_t     st_r, st_nxt;
  logic [NW-1:0]  norm_r, norm_nxt;
  logic [NBW-1:0] n_r, n_nxt;
  logic [31:0]    m_r, m_nxt;
  logic [16:0]    q_r, q_nxt;
  logic [4:0]     k_r, k_nxt;
  logic [63:0]    prod;
  logic [32:0]    sq;
  logic [LW:0]    rnd;

  assign prod = m_r * m_r;
  assign sq   = prod[63:31];
  assign rnd  = {1'b0, n_r, q_r} + {{LW{1'b0}}, 1'b1};
  assign res  = 32'(rnd[LW:1]);
  assign done = (st_r == L_DONE);

  always_comb begin
    st_nxt   = st_r;
    norm_nxt = norm_r;
    n_nxt    = n_r;
    m_nxt    = m_r;
    q_nxt    = q_r;
    k_nxt    = k_r;
    case (st_r)
      L_IDLE, L_DONE: begin
        if (start) begin
          norm_nxt = NW'(x);
          n_nxt    = NBW'(NW - 1);
          st_nxt   = L_NORM;
        end else begin
          st_nxt = L_IDLE;
        end
      end
      L_NORM: begin
        // one bit of the leading-one search a cycle
        if (norm_r[NW-1]) begin
          m_nxt  = norm_r[NW-1 -: 32];
          q_nxt  = '0;
          k_nxt  = '0;
          st_nxt = L_SQ;
        end else begin
          norm_nxt = {norm_r[NW-2:0], 1'b0};
          n_nxt    = n_r - {{(NBW-1){1'b0}}, 1'b1};
        end
      end
      L_SQ: begin
        if (sq[32]) begin
          q_nxt = {q_r[15:0], 1'b1};
          m_nxt = sq[32:1];
        end else begin
          q_nxt = {q_r[15:0], 1'b0};
          m_nxt = sq[31:0];
        end
        k_nxt = k_r + 5'd1;
        if (k_r == 5'd16) begin
          st_nxt = L_DONE;
        end
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    norm_r <= norm_nxt;
    n_r    <= n_nxt;
    m_r    <= m_nxt;
    q_r    <= q_nxt;
    k_r    <= k_nxt;
  end

endmodule
`default_nettype wire

/* hdl/mebm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module mebm_back
  import mebm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_nonempty,
  input  wire logic [7:0]  q_head,
  output logic             pop,
  input  wire logic [15:0] target,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  localparam int CW = COUNT_BITS;
  localparam int XW = CW + 6;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  logic [CW-1:0] pair_mem [0:65535];
  logic [CW-1:0] ctx_mem  [0:255];

  back_state_t st_r, st_nxt;
  logic [15:0]   clr_r, clr_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [7:0]    cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   l1_r, l1_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic [CW-1:0] ctx_rd_r, pair_rd_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          pair_we, ctx_we;
  logic [15:0]   pair_addr;
  logic [7:0]    ctx_addr;
  logic [CW-1:0] pair_wd, ctx_wd, total;
  logic          log_start, log_done;
  logic [XW-1:0] log_x;
  logic [31:0]   log_res;
  logic [33:0]   acc;

  mebm_log #(.XW(XW)) u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .res   (log_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign total     = (ctx_rd_r == CNT_MAX) ? ctx_rd_r : ctx_rd_r + {{(CW-1){1'b0}}, 1'b1};
  assign acc       = {2'b00, sum_r} + {2'b00, l1_r} - {2'b00, log_res};

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    l1_nxt        = l1_r;
    sum_nxt       = sum_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop           = 1'b0;
    pair_we       = 1'b0;
    ctx_we        = 1'b0;
    pair_addr     = {prev_r, cur_r};
    ctx_addr      = prev_r;
    pair_wd       = '0;
    ctx_wd        = '0;
    log_start     = 1'b0;
    log_x         = '0;
    case (st_r)
      B_CLEAR: begin
        pair_we   = 1'b1;
        ctx_we    = 1'b1;
        pair_addr = clr_r;
        ctx_addr  = clr_r[7:0];
        clr_nxt   = clr_r + 16'd1;
        if (clr_r == 16'hFFFF) begin
          st_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_nonempty) begin
          pop     = 1'b1;
          cur_nxt = q_head;
          st_nxt  = B_READ;
        end
      end
      B_READ: st_nxt = B_UPD;
      B_UPD: begin
        ctx_we    = 1'b1;
        ctx_wd    = total;
        pair_we   = 1'b1;
        pair_wd   = (pair_rd_r == CNT_MAX) ? pair_rd_r
                                           : pair_rd_r + {{(CW-1){1'b0}}, 1'b1};
        cnt_nxt   = pair_rd_r;
        log_start = 1'b1;
        log_x     = ({6'b0, total} << 5) + ({6'b0, total} << 4);
        st_nxt    = B_LOG1;
      end
      B_LOG1: begin
        if (log_done) begin
          l1_nxt    = log_res;
          log_start = 1'b1;
          log_x     = ({6'b0, cnt_r} << 5) + ({6'b0, cnt_r} << 4) + {{(XW-1){1'b0}}, 1'b1};
          st_nxt    = B_LOG2;
        end
      end
      B_LOG2: begin
        if (log_done) begin
          // clamp below at zero, above at all ones
          if (acc[33]) begin
            sum_nxt = '0;
          end else if (acc[32]) begin
            sum_nxt = 32'hFFFF_FFFF;
          end else begin
            sum_nxt = acc[31:0];
          end
          prev_nxt = cur_r;
          st_nxt   = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.mixed_byte       = prev_r;
          out_nxt.entropy_estimate = sum_r;
          out_nxt.target_reached   = (sum_r >= {target, 16'b0});
          out_valid_nxt            = 1'b1;
          st_nxt                   = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_CLEAR;
      clr_r       <= '0;
      prev_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    cnt_r <= cnt_nxt;
    l1_r  <= l1_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_addr] <= pair_wd;
    end
    pair_rd_r <= pair_mem[{prev_r, cur_r}];
  end

  always_ff @(posedge clk) begin
    if (ctx_we) begin
      ctx_mem[ctx_addr] <= ctx_wd;
    end
    ctx_rd_r <= ctx_mem[prev_r];
  end

endmodule
`default_nettype wire

/* hdl/mebm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module mebm_checker
  import mebm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire in_item_t    in_data,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire out_item_t   out_data,
  input wire logic        cfg_we,
  input wire logic [15:0] cfg_wdata
);

  logic [15:0] tgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= TARGET_RESET;
    end else if (cfg_we) begin
      tgt_r <= cfg_wdata;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // flag agrees with estimate and the written target
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.target_reached ==
                  (out_data.entropy_estimate >= {tgt_r, 16'b0}))
    else $error("target flag does not match estimate");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind markov_entropy_byte_mixer mebm_checker u_chk (.*);
`default_nettype wire
